// File: rtl/mthp_pkg.sv
package mthp_pkg;

  localparam int unsigned RULE_COUNT = 51;
  localparam int unsigned NAME_LEN   = 8;
  localparam int unsigned STATE_CNT  = 13;

  // Parse states with a meaning of their own; the rest are table-driven.
  localparam logic [3:0] ST_ACCEPT = 4'd1;
  localparam logic [3:0] ST_START  = 4'd2;
  localparam logic [3:0] ST_QVALUE = 4'hd;
  localparam logic [3:0] ST_LAST   = 4'he;

  // Character classes.
  localparam logic [3:0] CC_END = 4'd1;
  localparam logic [3:0] CC_SEP = 4'd9;

  // Result actions.
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_TYPE   = 3'd1;
  localparam logic [2:0] ACT_NAME   = 3'd2;
  localparam logic [2:0] ACT_VALUE  = 3'd3;
  localparam logic [2:0] ACT_PARAM  = 3'd4;
  localparam logic [2:0] ACT_CLOSE  = 3'd5;

  // Result status.
  localparam logic [1:0] STS_BUSY   = 2'd0;
  localparam logic [1:0] STS_ACCEPT = 2'd1;
  localparam logic [1:0] STS_REJECT = 2'd2;

  localparam logic [7:0] BACKSLASH = 8'h5c;

  localparam logic [3:0] CHAR_CLASS [128] = '{
    4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd3,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,
    4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,
    4'd3,4'd2,4'd7,4'd2,4'd2,4'd2,4'd2,4'd2,4'd9,4'd9,4'd2,4'd2,4'd9,4'd2,4'd2,4'd6,
    4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd9,4'd4,4'd9,4'd5,4'd9,4'd9,
    4'd9,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,
    4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd9,4'd8,4'd9,4'd2,4'd2,
    4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,
    4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd2,4'd9,4'd2,4'd9,4'd2,4'd0
  };

  localparam logic signed [7:0] STATE_BASE [STATE_CNT] = '{
    -8'sd2, 8'sd1, 8'sd4, 8'sd7, 8'sd13, 8'sd16, 8'sd10, 8'sd21, 8'sd18, 8'sd26,
    8'sd29, 8'sd37, 8'sd46
  };

  // Bits 3..0 owning state, bits 7..4 next state, bits 11..8 action.
  localparam logic [11:0] RULE_TAB [RULE_COUNT] = '{
    12'h132, 12'h022, 12'h013, 12'h133, 12'h063, 12'h073, 12'h154, 12'h143,
    12'h015, 12'h155, 12'h065, 12'h075, 12'h288, 12'h098, 12'h016, 12'h5a8,
    12'h066, 12'h076, 12'h287, 12'h077, 12'h3ba, 12'h0aa, 12'h000, 12'h000,
    12'h099, 12'h0da, 12'h5a9, 12'h41b, 12'h3bb, 12'h46b, 12'h47b, 12'h3dc,
    12'h3dc, 12'h3dc, 12'h3dc, 12'h3dc, 12'h3dc, 12'h3dc, 12'h3dc, 12'h3dd,
    12'h3dd, 12'h3dd, 12'h3dd, 12'h3dd, 12'h0ed, 12'h0cd, 12'h3dd, 12'h41e,
    12'h000, 12'h46e, 12'h47e
  };

  localparam logic [7:0] TARGET_NAME [NAME_LEN] = '{
    8'h66, 8'h69, 8'h6c, 8'h65, 8'h6e, 8'h61, 8'h6d, 8'h65
  };

  // Returns the rule at the state's base plus class, or zero out of range.
  function automatic logic [11:0] rule_lookup(input logic [3:0] st, input logic [3:0] cls);
    logic signed [7:0] idx;
    logic [3:0]        row;
    logic [11:0]       r;
    r   = '0;
    row = st - ST_START;
    idx = '0;
    if (st >= ST_START && st <= ST_LAST) begin
      idx = STATE_BASE[row] + $signed({4'b0000, cls});
      if (idx >= 0 && idx < 8'(RULE_COUNT)) begin
        r = RULE_TAB[idx[5:0]];
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/media_type_header_parser.sv
// Media-type header parser: one byte of a Content-Type or Content-Disposition
// value per beat, with in_tlast marking the end of the value (its data byte is
// ignored). Every input beat yields exactly one registered result beat in the
// next cycle, and a beat can be taken in every cycle: the class lookup, rule
// lookup and state update are combinational up to the state register, and the
// input is ready whenever the result register is empty or its beat leaves in
// the same cycle. While a result is stalled the input is held off. After a
// rejection all bytes up to the end marker give rejected results with no action.
module media_type_header_parser
  import mthp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] octet
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] char_out, [9:8] status, rest zero
  output logic [3:0]  out_tuser   // [2:0] action, [3] in_filename
);

  logic [3:0] parse_state_r, parse_state_nxt;
  logic [3:0] match_idx_r, match_idx_nxt;
  logic       mismatch_r, mismatch_nxt;
  logic       fname_flag_r, fname_flag_nxt;
  logic       reject_hold_r, reject_hold_nxt;

  logic       out_valid_r;
  logic [7:0] char_r, char_nxt;
  logic [1:0] status_r, status_nxt;
  logic [2:0] action_r, action_nxt;
  logic       fname_out_r, fname_out_nxt;

  logic       accept;
  logic [7:0] octet;
  logic [7:0] low_octet;
  logic [3:0] cls;
  logic [11:0] rule;
  logic [3:0] nxt_st;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign octet     = in_tdata;
  assign low_octet = (octet >= 8'h41 && octet <= 8'h5a) ? (octet | 8'h20) : octet;

  always_comb begin
    if (in_tlast) begin
      cls = CC_END;
    end else if (octet[7]) begin
      cls = CC_SEP;
    end else if (parse_state_r == ST_QVALUE && fname_flag_r && octet == BACKSLASH) begin
      // A backslash in a quoted filename is a literal byte, not an escape.
      cls = CC_SEP;
    end else begin
      cls = CHAR_CLASS[octet[6:0]];
    end
    rule   = rule_lookup(parse_state_r, cls);
    nxt_st = (rule[3:0] == parse_state_r) ? rule[7:4] : 4'd0;
  end

  always_comb begin
    parse_state_nxt = parse_state_r;
    match_idx_nxt   = match_idx_r;
    mismatch_nxt    = mismatch_r;
    fname_flag_nxt  = fname_flag_r;
    reject_hold_nxt = reject_hold_r;
    action_nxt      = ACT_NONE;
    char_nxt        = 8'h00;
    status_nxt      = STS_BUSY;
    fname_out_nxt   = 1'b0;
    if (reject_hold_r) begin
      status_nxt = STS_REJECT;
      if (in_tlast) begin
        reject_hold_nxt = 1'b0;
        parse_state_nxt = ST_START;
        match_idx_nxt   = '0;
        mismatch_nxt    = 1'b0;
        fname_flag_nxt  = 1'b0;
      end
    end else if (nxt_st == 4'd0) begin
      status_nxt      = STS_REJECT;
      fname_out_nxt   = fname_flag_r;
      parse_state_nxt = ST_START;
      match_idx_nxt   = '0;
      mismatch_nxt    = 1'b0;
      fname_flag_nxt  = 1'b0;
      reject_hold_nxt = !in_tlast;
    end else begin
      case (rule[11:8])
        4'(ACT_TYPE): begin
          action_nxt = ACT_TYPE;
          char_nxt   = low_octet;
        end
        4'(ACT_NAME): begin
          action_nxt = ACT_NAME;
          char_nxt   = low_octet;
          if (match_idx_r[3] || TARGET_NAME[match_idx_r[2:0]] != low_octet) begin
            mismatch_nxt = 1'b1;
          end else begin
            match_idx_nxt = match_idx_r + 4'd1;
          end
        end
        4'(ACT_VALUE): begin
          action_nxt = ACT_VALUE;
          char_nxt   = octet;
        end
        4'(ACT_PARAM): begin
          action_nxt    = ACT_PARAM;
          match_idx_nxt = '0;
          mismatch_nxt  = 1'b0;
        end
        4'(ACT_CLOSE): begin
          action_nxt     = ACT_CLOSE;
          fname_flag_nxt = !mismatch_r && match_idx_r == 4'(NAME_LEN);
        end
        default: begin
          action_nxt = ACT_NONE;
        end
      endcase
      fname_out_nxt = fname_flag_nxt;
      if (nxt_st == ST_ACCEPT) begin
        status_nxt      = STS_ACCEPT;
        parse_state_nxt = ST_START;
        match_idx_nxt   = '0;
        mismatch_nxt    = 1'b0;
        fname_flag_nxt  = 1'b0;
      end else begin
        parse_state_nxt = nxt_st;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_state_r <= ST_START;
      match_idx_r   <= '0;
      mismatch_r    <= 1'b0;
      fname_flag_r  <= 1'b0;
      reject_hold_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        parse_state_r <= parse_state_nxt;
        match_idx_r   <= match_idx_nxt;
        mismatch_r    <= mismatch_nxt;
        fname_flag_r  <= fname_flag_nxt;
        reject_hold_r <= reject_hold_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r    <= action_nxt;
      char_r      <= char_nxt;
      status_r    <= status_nxt;
      fname_out_r <= fname_out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, status_r, char_r};
  assign out_tuser  = {fname_out_r, action_r};

`ifndef ASSERT_OFF
  a_hold_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    reject_hold_r |-> (parse_state_r == ST_START && !fname_flag_r && match_idx_r == 4'd0))
    else $error("swallowing without a restarted parser");

  a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
    match_idx_r <= 4'(NAME_LEN))
    else $error("name match index past the name length");

  a_reject_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == STS_REJECT) |-> (action_r == ACT_NONE && char_r == 8'h00))
    else $error("rejected beat carries an action");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(action_r) && $stable(char_r)))
    else $error("stalled result changed");
`endif

endmodule
